/* design/nts_pkg.sv */
// Shared types, state codes and helpers for the navigation task state machine.
`default_nettype none

package nts_pkg;

    // One-hot task states
    typedef enum logic [8:0] {
        ST_WAITING   = 9'b000000001,
        ST_FIRST     = 9'b000000010,
        ST_PROGRESS  = 9'b000000100,
        ST_PAUSING   = 9'b000001000,
        ST_PAUSED    = 9'b000010000,
        ST_RESUMING  = 9'b000100000,
        ST_CANCELING = 9'b001000000,
        ST_FAILED    = 9'b010000000,
        ST_DONE      = 9'b100000000
    } nav_state_t;

    // Encoded task state as seen on the result port
    localparam logic [3:0] CODE_WAITING   = 4'd0;
    localparam logic [3:0] CODE_FIRST     = 4'd1;
    localparam logic [3:0] CODE_PROGRESS  = 4'd2;
    localparam logic [3:0] CODE_PAUSING   = 4'd3;
    localparam logic [3:0] CODE_PAUSED    = 4'd4;
    localparam logic [3:0] CODE_RESUMING  = 4'd5;
    localparam logic [3:0] CODE_CANCELING = 4'd6;
    localparam logic [3:0] CODE_FAILED    = 4'd7;
    localparam logic [3:0] CODE_DONE      = 4'd8;

    // Control notices raised on state entry
    localparam logic [1:0] CTRL_NONE   = 2'd0;
    localparam logic [1:0] CTRL_PAUSE  = 2'd1;
    localparam logic [1:0] CTRL_RESUME = 2'd2;
    localparam logic [1:0] CTRL_CANCEL = 2'd3;

    // One result transaction
    typedef struct packed {
        logic        rejected;
        logic [3:0]  task_state;
        logic [1:0]  control_event;
        logic        next_node_event;
        logic        segment_event;
        logic [31:0] event_segment_begin;
        logic [31:0] event_segment_end;
        logic        done_event;
        logic [31:0] done_sequence;
    } nts_result_t;

    // Map a one-hot state onto its port code
    function automatic logic [3:0] state_code(input nav_state_t st);
        logic [3:0] code;
        begin
            case (st)
                ST_WAITING:   code = CODE_WAITING;
                ST_FIRST:     code = CODE_FIRST;
                ST_PROGRESS:  code = CODE_PROGRESS;
                ST_PAUSING:   code = CODE_PAUSING;
                ST_PAUSED:    code = CODE_PAUSED;
                ST_RESUMING:  code = CODE_RESUMING;
                ST_CANCELING: code = CODE_CANCELING;
                ST_FAILED:    code = CODE_FAILED;
                ST_DONE:      code = CODE_DONE;
                default:      code = CODE_WAITING;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

/* design/nts_next.sv */
// Transition table and entry effects of the navigation task state machine.
`default_nettype none

module nts_next
    import nts_pkg::*;
(
    input  nav_state_t  state,
    input  logic [2:0]  action,
    input  logic [31:0] seq_id,
    input  logic [31:0] goal_sequence,
    input  logic        segment_present,
    input  logic [31:0] segment_begin,
    input  logic [31:0] segment_end,
    output nav_state_t  state_next,
    output nts_result_t result
);

    localparam logic [2:0] ACT_START   = 3'd0;
    localparam logic [2:0] ACT_RESUMED = 3'd1;
    localparam logic [2:0] ACT_PAUSE   = 3'd2;
    localparam logic [2:0] ACT_PAUSED  = 3'd3;
    localparam logic [2:0] ACT_RESUME  = 3'd4;
    localparam logic [2:0] ACT_REACHED = 3'd5;
    localparam logic [2:0] ACT_CANCEL  = 3'd6;
    localparam logic [2:0] ACT_FAILED  = 3'd7;

    logic       match;
    logic       ok;
    nav_state_t target;

    // Look up the target state of this event
    always_comb
    begin
        match  = (seq_id == goal_sequence);
        ok     = 1'b1;
        target = state;
        case (state)
            ST_WAITING:
            begin
                case (action)
                    ACT_START:  target = ST_FIRST;
                    ACT_CANCEL: target = ST_CANCELING;
                    ACT_FAILED: target = ST_FAILED;
                    default:    ok = 1'b0;
                endcase
            end
            ST_FIRST, ST_PROGRESS:
            begin
                case (action)
                    ACT_CANCEL:  target = ST_CANCELING;
                    ACT_PAUSE:   target = ST_PAUSING;
                    ACT_FAILED:  target = ST_FAILED;
                    ACT_PAUSED:  target = ST_PAUSED;
                    ACT_REACHED:
                    begin
                        if (match) target = ST_DONE;
                        else       ok = 1'b0;
                    end
                    default:     ok = 1'b0;
                endcase
            end
            ST_PAUSING:
            begin
                case (action)
                    ACT_CANCEL:  target = ST_CANCELING;
                    ACT_PAUSED:  target = ST_PAUSED;
                    ACT_FAILED:  target = ST_FAILED;
                    ACT_REACHED:
                    begin
                        if (match) target = ST_DONE;
                        else       ok = 1'b0;
                    end
                    default:     ok = 1'b0;
                endcase
            end
            ST_PAUSED:
            begin
                case (action)
                    ACT_CANCEL:  target = ST_CANCELING;
                    ACT_RESUME:  target = ST_RESUMING;
                    ACT_RESUMED: target = ST_PROGRESS;
                    ACT_FAILED:  target = ST_FAILED;
                    default:     ok = 1'b0;
                endcase
            end
            ST_RESUMING:
            begin
                case (action)
                    ACT_CANCEL:  target = ST_CANCELING;
                    ACT_RESUMED: target = ST_PROGRESS;
                    ACT_FAILED:  target = ST_FAILED;
                    ACT_PAUSED:  target = ST_PAUSED;
                    default:     ok = 1'b0;
                endcase
            end
            ST_CANCELING:
            begin
                case (action)
                    ACT_FAILED:  target = ST_FAILED;
                    ACT_REACHED:
                    begin
                        if (match) target = ST_DONE;
                        else       ok = 1'b0;
                    end
                    default:     ok = 1'b0;
                endcase
            end
            // failed and done are terminal
            default: ok = 1'b0;
        endcase
    end

    // Build the entry effects of the new state
    always_comb
    begin
        state_next = ok ? target : state;
        result     = '0;
        result.rejected   = ~ok;
        result.task_state = state_code(state_next);
        if (ok)
        begin
            case (target)
                ST_FIRST:
                begin
                    result.next_node_event = 1'b1;
                    if (segment_present)
                    begin
                        result.segment_event       = 1'b1;
                        result.event_segment_begin = segment_begin;
                        result.event_segment_end   = segment_end;
                    end
                end
                ST_PAUSING:   result.control_event = CTRL_PAUSE;
                ST_RESUMING:  result.control_event = CTRL_RESUME;
                ST_CANCELING: result.control_event = CTRL_CANCEL;
                ST_DONE:
                begin
                    result.done_event    = 1'b1;
                    result.done_sequence = goal_sequence;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/navigation_task_state_machine.sv */
// Navigation task state machine: input register, transition logic, result register.
// An accepted transaction is held in the input register, and its result then in the result register.
// Throughput: one transaction per cycle while the output is not stalled, set by the single state register update.
// While a result waits on the output, the input register holds one more transaction,
// then the input stalls until the result is taken.
// Reset (rst_n low, asynchronous): state to waiting, config registers to 0, both stages empty.
`default_nettype none

module navigation_task_state_machine
    import nts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  action,
    input  wire logic [31:0] seq_id,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             rejected,
    output logic [3:0]       task_state,
    output logic [1:0]       control_event,
    output logic             next_node_event,
    output logic             segment_event,
    output logic [31:0]      event_segment_begin,
    output logic [31:0]      event_segment_end,
    output logic             done_event,
    output logic [31:0]      done_sequence
);

    localparam logic [1:0] CFG_GOAL_SEQUENCE   = 2'd0;
    localparam logic [1:0] CFG_SEGMENT_PRESENT = 2'd1;
    localparam logic [1:0] CFG_SEGMENT_BEGIN   = 2'd2;
    localparam logic [1:0] CFG_SEGMENT_END     = 2'd3;

    logic [31:0] goal_sequence_reg;
    logic        segment_present_reg;
    logic [31:0] segment_begin_reg;
    logic [31:0] segment_end_reg;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [2:0]  action_reg;
    logic [31:0] seq_id_reg;

    nav_state_t  state_reg;
    nav_state_t  state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    nts_result_t res_reg;
    nts_result_t res_next;

    logic        in_take;
    logic        advance;

    // Handshake control
    assign advance        = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall       = in_valid_reg & ~advance;
    assign in_take        = in_valid & ~in_stall;
    assign in_valid_next  = in_take | (in_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & out_stall);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_sequence_reg   <= '0;
            segment_present_reg <= 1'b0;
            segment_begin_reg   <= '0;
            segment_end_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GOAL_SEQUENCE:   goal_sequence_reg   <= cfg_data;
                CFG_SEGMENT_PRESENT: segment_present_reg <= cfg_data[0];
                CFG_SEGMENT_BEGIN:   segment_begin_reg   <= cfg_data;
                CFG_SEGMENT_END:     segment_end_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Transition logic
    nts_next u_next (
        .state           (state_reg),
        .action          (action_reg),
        .seq_id          (seq_id_reg),
        .goal_sequence   (goal_sequence_reg),
        .segment_present (segment_present_reg),
        .segment_begin   (segment_begin_reg),
        .segment_end     (segment_end_reg),
        .state_next      (state_next),
        .result          (res_next)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_WAITING;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= action;
            seq_id_reg <= seq_id;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid           = out_valid_reg;
    assign rejected            = res_reg.rejected;
    assign task_state          = res_reg.task_state;
    assign control_event       = res_reg.control_event;
    assign next_node_event     = res_reg.next_node_event;
    assign segment_event       = res_reg.segment_event;
    assign event_segment_begin = res_reg.event_segment_begin;
    assign event_segment_end   = res_reg.event_segment_end;
    assign done_event          = res_reg.done_event;
    assign done_sequence       = res_reg.done_sequence;

    // A pending result always reports the current task state
    a_state_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.task_state == state_code(state_reg)))
        else $error("result task_state differs from state register");

    // A rejected transaction raises no effect
    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.rejected) |->
            (res_reg.control_event == CTRL_NONE && !res_reg.next_node_event &&
             !res_reg.segment_event && !res_reg.done_event))
        else $error("rejected transaction carries an effect");

    // A done notice only comes with the done state
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done_event) |->
            (res_reg.task_state == CODE_DONE && state_reg == ST_DONE))
        else $error("done event outside done state");

endmodule

`default_nettype wire
